// ----- hw/rtl/rgpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rgpc_pkg
// Shared types, register map and constants of the progress-ring pixel
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rgpc_pkg;

  // Pixel and register field widths
  localparam int COORD_W  = 10;
  localparam int RADIUS_W = 9;
  localparam int PROG_W   = 16;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  // Register map (index = paddr[4:2])
  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_OUTER_RAD  = 3'd2;
  localparam logic [2:0] REG_THICKNESS  = 3'd3;
  localparam logic [2:0] REG_PROG_VALUE = 3'd4;
  localparam logic [2:0] REG_PROG_MAX   = 3'd5;

  localparam logic [RADIUS_W-1:0] THICK_DEFAULT = RADIUS_W'(4);

  // Region codes
  localparam logic [1:0] REGION_OUTSIDE = 2'd0;
  localparam logic [1:0] REGION_FILLED  = 2'd1;
  localparam logic [1:0] REGION_DITHER  = 2'd2;

  // Percentage scale
  localparam int PCT_FULL = 100;
  localparam int PCT_W    = 7;
  localparam int NUM_W    = 32;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_SCALE = 24;
  localparam int XW           = COORD_W + CORDIC_SCALE + 3;
  localparam int ZW           = 33;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic       pixel_on;
    logic [1:0] region;
  } out_item_t;

  // Sideband that rides along the CORDIC pipe
  typedef struct packed {
    logic       in_band;
    logic       dither;
    logic       center;
    logic       swap;
    logic [1:0] quad;
  } side_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ring_gauge_pixel_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// ring_gauge_pixel_classifier_unit
// Classifies raster pixels against a progress-ring gauge: outside the band,
// filled arc, or dithered unfilled band.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_item with a pixel coordinate and raise start; the item is
//   taken at any edge where start is high and busy is low. One pixel per
//   clock is sustained outside busy, so a raster scan can stream straight in.
//   Output: out_valid pulses for one cycle with out_item (pixel_on, region).
//   The receiver cannot stall; out_valid follows the accept edge through 3
//   front stages, 30 CORDIC stages, angle fold and compare.
//   Config: APB registers at 4*i (center x/y, outer radius, thickness,
//   progress value, progress max). Write only when the pipe is empty.
//   Writing progress value or max reruns the end-angle conversion: busy is
//   high after such a write through the load, a 32-step restoring divide
//   for the percentage and the scale to an angle (no divide when progress
//   max is zero); no pixel is taken meanwhile. Other writes cost nothing.
//   Reset: config returns to defaults (thickness 4, rest 0), pipe valids
//   clear, end angle is zero; busy is low right after reset.
//   Latency through the CORDIC column is fixed; throughput is one item per
//   cycle except while the end-angle conversion runs.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_gauge_pixel_classifier_unit import rgpc_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // pixel input
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  // result strobe
  output logic              out_valid,
  output out_item_t         out_item,
  // APB config
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int LATENCY = 35;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SQS_W   = SQ_W + 2;
  localparam int D2_W    = SQ_W + 1;
  localparam int R2_W    = 2 * RADIUS_W;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0]  center_x_r, center_y_r;
  logic [RADIUS_W-1:0] outer_rad_r, thickness_r;
  logic [PROG_W-1:0]   prog_value_r, prog_max_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       kick;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign kick    = cfg_wr && ((cfg_idx == REG_PROG_VALUE) || (cfg_idx == REG_PROG_MAX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= '0;
      center_y_r   <= '0;
      outer_rad_r  <= '0;
      thickness_r  <= THICK_DEFAULT;
      prog_value_r <= '0;
      prog_max_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CENTER_X:   center_x_r   <= pwdata[COORD_W-1:0];
        REG_CENTER_Y:   center_y_r   <= pwdata[COORD_W-1:0];
        REG_OUTER_RAD:  outer_rad_r  <= pwdata[RADIUS_W-1:0];
        REG_THICKNESS:  thickness_r  <= pwdata[RADIUS_W-1:0];
        REG_PROG_VALUE: prog_value_r <= pwdata[PROG_W-1:0];
        REG_PROG_MAX:   prog_max_r   <= pwdata[PROG_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTER_X:   prdata = CFG_DW'(center_x_r);
      REG_CENTER_Y:   prdata = CFG_DW'(center_y_r);
      REG_OUTER_RAD:  prdata = CFG_DW'(outer_rad_r);
      REG_THICKNESS:  prdata = CFG_DW'(thickness_r);
      REG_PROG_VALUE: prdata = CFG_DW'(prog_value_r);
      REG_PROG_MAX:   prdata = CFG_DW'(prog_max_r);
      default:        prdata = '0;
    endcase
  end

  // Band limits, squared, in registers. Config must stay static while pixels
  // flow; the block does not enforce it. They settle the cycle after a write.
  logic [RADIUS_W-1:0] thick_eff, inner;
  logic [R2_W-1:0]     inner2_r, r2_r;

  always_comb begin
    thick_eff = (thickness_r == '0) ? THICK_DEFAULT : thickness_r;
    // thickness past the radius gives a full disc
    inner     = (outer_rad_r >= thick_eff) ? outer_rad_r - thick_eff : '0;
  end

  always_ff @(posedge clk) begin
    inner2_r <= R2_W'(inner) * R2_W'(inner);
    r2_r     <= R2_W'(outer_rad_r) * R2_W'(outer_rad_r);
  end

  // --------------------------------------------------------------------------
  // End angle of the filled arc
  // --------------------------------------------------------------------------
  logic [ANGLE_WIDTH:0] fill_end;

  rgpc_scale #(
    .ANGLE_W (ANGLE_WIDTH)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .kick       (kick),
    .prog_value (prog_value_r),
    .prog_max   (prog_max_r),
    .busy       (busy),
    .fill_end   (fill_end)
  );

  // --------------------------------------------------------------------------
  // S1: offsets from the center, dither phase
  // --------------------------------------------------------------------------
  logic                    accept;
  logic                    v1_r;
  logic signed [COORD_W:0] dx1_r, dy1_r;
  logic                    dith1_r;
  logic [1:0]              phase;

  assign accept = start && !busy;
  assign phase  = in_item.pixel_x[1:0] + in_item.pixel_y[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    dx1_r   <= $signed({1'b0, in_item.pixel_x}) - $signed({1'b0, center_x_r});
    dy1_r   <= $signed({1'b0, in_item.pixel_y}) - $signed({1'b0, center_y_r});
    dith1_r <= (phase == 2'd0);
  end

  // --------------------------------------------------------------------------
  // S2: squares, quadrant fold to leg pair (a, b)
  // --------------------------------------------------------------------------
  logic                      v2_r;
  logic [SQ_W-1:0]           sqx2_r, sqy2_r;
  logic [COORD_W-1:0]        a2_r, b2_r;
  logic [1:0]                quad2_r;
  logic                      ctr2_r, dith2_r;
  logic signed [2*COORD_W+1:0] sqx, sqy;
  logic signed [COORD_W:0]   ndx, ndy;
  logic [COORD_W-1:0]        a_fold, b_fold;
  logic [1:0]                quad;

  always_comb begin
    sqx = SQS_W'(dx1_r) * SQS_W'(dx1_r);
    sqy = SQS_W'(dy1_r) * SQS_W'(dy1_r);
    ndx = -dx1_r;
    ndy = -dy1_r;
    if (!dx1_r[COORD_W] && dy1_r[COORD_W]) begin
      quad   = 2'd0;
      a_fold = ndy[COORD_W-1:0];
      b_fold = dx1_r[COORD_W-1:0];
    end else if (!dx1_r[COORD_W] && (dx1_r != '0) && !dy1_r[COORD_W]) begin
      quad   = 2'd1;
      a_fold = dx1_r[COORD_W-1:0];
      b_fold = dy1_r[COORD_W-1:0];
    end else if ((dx1_r[COORD_W] || (dx1_r == '0)) && !dy1_r[COORD_W] && (dy1_r != '0)) begin
      quad   = 2'd2;
      a_fold = dy1_r[COORD_W-1:0];
      b_fold = ndx[COORD_W-1:0];
    end else begin
      quad   = 2'd3;
      a_fold = ndx[COORD_W-1:0];
      b_fold = ndy[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sqx2_r  <= sqx[SQ_W-1:0];
    sqy2_r  <= sqy[SQ_W-1:0];
    a2_r    <= a_fold;
    b2_r    <= b_fold;
    quad2_r <= quad;
    ctr2_r  <= (dx1_r == '0) && (dy1_r == '0);
    dith2_r <= dith1_r;
  end

  // --------------------------------------------------------------------------
  // S3: band test, octant swap, CORDIC seed
  // --------------------------------------------------------------------------
  logic                 v3_r;
  logic signed [XW-1:0] x3_r, y3_r;
  side_t                side3_r;
  logic [D2_W-1:0]      d2;
  logic                 swap;
  logic [COORD_W-1:0]   lx, ly;

  always_comb begin
    d2   = {1'b0, sqx2_r} + {1'b0, sqy2_r};
    swap = b2_r > a2_r;
    lx   = swap ? b2_r : a2_r;
    ly   = swap ? a2_r : b2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    x3_r            <= $signed({{(XW-COORD_W-CORDIC_SCALE){1'b0}}, lx, {CORDIC_SCALE{1'b0}}});
    y3_r            <= $signed({{(XW-COORD_W-CORDIC_SCALE){1'b0}}, ly, {CORDIC_SCALE{1'b0}}});
    side3_r.in_band <= (d2 >= D2_W'(inner2_r)) && (d2 <= D2_W'(r2_r));
    side3_r.dither  <= dith2_r;
    side3_r.center  <= ctr2_r;
    side3_r.swap    <= swap;
    side3_r.quad    <= quad2_r;
  end

  // --------------------------------------------------------------------------
  // CORDIC column
  // --------------------------------------------------------------------------
  logic                 vc;
  logic signed [ZW-1:0] zc;
  side_t                sc;

  rgpc_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v3_r),
    .in_x     (x3_r),
    .in_y     (y3_r),
    .in_side  (side3_r),
    .out_vld  (vc),
    .out_z    (zc),
    .out_side (sc)
  );

  // --------------------------------------------------------------------------
  // S4: clamp, unfold octant and quadrant, truncate to binary angle
  // --------------------------------------------------------------------------
  logic                   v4_r;
  logic [ANGLE_WIDTH-1:0] ang4_r;
  logic                   band4_r, dith4_r;
  logic [29:0]            zclamp;
  logic [30:0]            phi;
  logic [31:0]            total;

  always_comb begin
    if (zc[ZW-1]) begin
      zclamp = '0;
    end else if (zc > ZW'(32'h2000_0000)) begin
      zclamp = 30'h2000_0000;
    end else begin
      zclamp = zc[29:0];
    end
    phi   = sc.swap ? (31'h4000_0000 - 31'(zclamp)) : 31'(zclamp);
    total = {sc.quad, 30'd0} + 32'(phi);
    // center pixel reads as angle zero
    if (sc.center) begin
      total = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= vc;
    end
  end

  always_ff @(posedge clk) begin
    ang4_r  <= total[31 -: ANGLE_WIDTH];
    band4_r <= sc.in_band;
    dith4_r <= sc.dither;
  end

  // --------------------------------------------------------------------------
  // S5: compare against end angle, result register
  // --------------------------------------------------------------------------
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  always_comb begin
    if (!band4_r) begin
      out_item_nxt.pixel_on = 1'b0;
      out_item_nxt.region   = REGION_OUTSIDE;
    end else if ({1'b0, ang4_r} <= fill_end) begin
      out_item_nxt.pixel_on = 1'b1;
      out_item_nxt.region   = REGION_FILLED;
    end else begin
      out_item_nxt.pixel_on = dith4_r;
      out_item_nxt.region   = REGION_DITHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching accepted item");

  a_busy_after_prog: assert property (@(posedge clk) disable iff (!rst_n)
    kick |=> busy)
    else $error("progress write did not hold off pixels");

  a_outside_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.region == REGION_OUTSIDE)) |-> !out_item.pixel_on)
    else $error("pixel lit outside band");

  a_filled_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.region == REGION_FILLED)) |-> out_item.pixel_on)
    else $error("filled arc pixel not lit");

endmodule

`default_nettype wire

// ----- hw/rtl/rgpc_scale.sv -----
// ----------------------------------------------------------------------------
// rgpc_scale
// Turns progress value/max into the end angle of the filled arc: a restoring
// divider gives the percentage, a reciprocal multiply scales it to an angle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgpc_scale import rgpc_pkg::*; #(
  parameter int ANGLE_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               kick,
  input  logic [PROG_W-1:0]  prog_value,
  input  logic [PROG_W-1:0]  prog_max,
  output logic               busy,
  output logic [ANGLE_W:0]   fill_end
);

  localparam int CNT_W     = $clog2(NUM_W);
  localparam int END_SHIFT = 14;
  localparam int K_W       = ANGLE_W + 8;
  localparam int PROD_W    = PCT_W + K_W;
  // ceil(2^(ANGLE_W+END_SHIFT) / 100); the rounding error stays below the
  // smallest fractional step of pct * 2^ANGLE_W / 100, so the floor is exact
  localparam logic [K_W-1:0] END_K =
    K_W'(((64'd1 << (ANGLE_W + END_SHIFT)) + 64'd99) / 64'd100);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PCT  = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              kick_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [PROG_W-1:0] rem_r, rem_nxt;
  logic [PROG_W-1:0] den_r, den_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;
  logic [ANGLE_W:0]  end_r, end_nxt;

  logic [PROG_W:0]   trial;
  logic              fits;
  logic [PROG_W-1:0] rem_step;
  logic [NUM_W-1:0]  num_step;
  logic [PCT_W-1:0]  pct;
  logic              last;
  logic [PROD_W-1:0] end_prod;

  always_comb begin
    trial    = {rem_r, num_r[NUM_W-1]};
    fits     = trial >= {1'b0, den_r};
    rem_step = fits ? PROG_W'(trial - {1'b0, den_r}) : trial[PROG_W-1:0];
    num_step = {num_r[NUM_W-2:0], fits};
    pct      = (num_step > NUM_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : num_step[PCT_W-1:0];
    last     = cnt_r == CNT_W'(NUM_W - 1);
    end_prod = PROD_W'(pct_r) * PROD_W'(END_K);

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    pct_nxt   = pct_r;
    end_nxt   = end_r;

    if (kick_r) begin
      // a progress write restarts the conversion from any state
      cnt_nxt = '0;
      rem_nxt = '0;
      if (prog_max == '0) begin
        // zero full scale: percentage is zero
        state_nxt = ST_END;
        pct_nxt   = '0;
      end else begin
        state_nxt = ST_PCT;
        num_nxt   = NUM_W'(prog_value) * NUM_W'(PCT_FULL);
        den_nxt   = prog_max;
      end
    end else begin
      case (state_r)
        ST_IDLE: ;
        ST_PCT: begin
          num_nxt = num_step;
          rem_nxt = rem_step;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (last) begin
            state_nxt = ST_END;
            pct_nxt   = pct;
          end
        end
        ST_END: begin
          state_nxt = ST_IDLE;
          end_nxt   = end_prod[END_SHIFT +: ANGLE_W+1];
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kick_r  <= 1'b0;
      cnt_r   <= '0;
      end_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kick_r  <= kick;
      cnt_r   <= cnt_nxt;
      end_r   <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    pct_r <= pct_nxt;
  end

  assign busy     = kick_r || (state_r != ST_IDLE);
  assign fill_end = end_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rgpc_cordic.sv -----
// ----------------------------------------------------------------------------
// rgpc_cordic
// Fully pipelined CORDIC vectoring: one micro-rotation per stage, atan(y/x)
// accumulated in 2^-32 turn units. Sideband travels with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module rgpc_cordic import rgpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  side_t                in_side,
  output logic                 out_vld,
  output logic signed [ZW-1:0] out_z,
  output side_t                out_side
);

  logic                 vld_r  [CORDIC_STEPS];
  logic signed [XW-1:0] x_r    [CORDIC_STEPS];
  logic signed [XW-1:0] y_r    [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r    [CORDIC_STEPS];
  side_t                side_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic                 vp;
    logic signed [XW-1:0] xp, yp, xs, ys, x_nxt, y_nxt;
    logic signed [ZW-1:0] zp, z_nxt, ang;
    side_t                sp;

    if (i == 0) begin : g_first
      assign vp = in_vld;
      assign xp = in_x;
      assign yp = in_y;
      assign zp = '0;
      assign sp = in_side;
    end else begin : g_next
      assign vp = vld_r[i-1];
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign sp = side_r[i-1];
    end

    always_comb begin
      xs  = xp >>> i;
      ys  = yp >>> i;
      ang = $signed({1'b0, atan_turn(5'(i))});
      if (yp == '0) begin
        // converged: later steps leave the vector alone
        x_nxt = xp;
        y_nxt = yp;
        z_nxt = zp;
      end else if (!yp[XW-1]) begin
        x_nxt = xp + ys;
        y_nxt = yp - xs;
        z_nxt = zp + ang;
      end else begin
        x_nxt = xp - ys;
        y_nxt = yp + xs;
        z_nxt = zp - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      x_r[i]    <= x_nxt;
      y_r[i]    <= y_nxt;
      z_r[i]    <= z_nxt;
      side_r[i] <= sp;
    end
  end

  assign out_vld  = vld_r[CORDIC_STEPS-1];
  assign out_z    = z_r[CORDIC_STEPS-1];
  assign out_side = side_r[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ----- tb/ring_gauge_pixel_classifier_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_gauge_pixel_classifier_unit_tb
// Streams pixel coordinates through the ring classifier under a series of
// gauge settings. Each accepted pixel is classified by a local model and the
// result strobes are checked in order, field by field.
// ----------------------------------------------------------------------------

module ring_gauge_pixel_classifier_unit_tb;
  import rgpc_pkg::*;

  localparam int ANGLE_W     = 16;
  localparam int LIMIT_CYC   = 200000;
  localparam int DRAIN_CYC   = 40;     // pipe is 35 stages deep
  localparam int RANDOM_PIX  = 900;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;

  // Register slots that decode to nothing; writes must be dropped.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // atan(2^-i) in 2^-32 turn units
  localparam bit [31:0] ATAN_LUT [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81, 41,
    20, 10, 5, 3, 1
  };

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Local copy of the gauge registers, kept in step with every write.
  bit [COORD_W-1:0]  ring_cx    = '0;
  bit [COORD_W-1:0]  ring_cy    = '0;
  bit [RADIUS_W-1:0] ring_r     = '0;
  bit [RADIUS_W-1:0] ring_t     = RADIUS_W'(4);
  bit [PROG_W-1:0]   prog_val   = '0;
  bit [PROG_W-1:0]   prog_full  = '0;

  in_item_t  scan_queue[$];        // pixels waiting to be driven
  out_item_t predicted_class[$];   // classifications of accepted pixels
  out_item_t want;

  bit item_taken = 1'b0;
  int gap_left   = 0;
  int gap_pct    = 0;
  int cycles     = 0;
  int mismatches = 0;
  int pixels_in  = 0;
  int settings   = 0;
  int region_hits[3] = '{0, 0, 0};

  ring_gauge_pixel_classifier_unit #(
    .ANGLE_WIDTH(ANGLE_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Classification model
  // --------------------------------------------------------------------------

  // Vectoring CORDIC: atan(b/a) for a > 0, 0 <= b <= a, in 2^-32 turn units.
  // >>> on a signed longint is a floor shift, which is what the pipe does.
  function automatic bit [31:0] octant_turns(longint a, longint b);
    longint x, y, z, xs, ys;
    int i;
    x = a <<< 24;
    y = b <<< 24;
    z = 0;
    for (i = 0; i < 30 && y != 0; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_LUT[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_LUT[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(1) <<< 29)) z = longint'(1) <<< 29;
    return z[31:0];
  endfunction

  // Clockwise angle from top, screen y down; 32-bit sum wraps at a full turn.
  function automatic bit [31:0] sweep_turns(longint dx, longint dy);
    longint a, b;
    bit [31:0] quarter, phi;
    if (dx == 0 && dy == 0) return 32'd0;
    if (dx >= 0 && dy < 0) begin
      quarter = 0; a = -dy; b = dx;
    end else if (dx > 0 && dy >= 0) begin
      quarter = 1; a = dx;  b = dy;
    end else if (dx <= 0 && dy > 0) begin
      quarter = 2; a = dy;  b = -dx;
    end else begin
      quarter = 3; a = -dx; b = -dy;
    end
    if (b > a) phi = 32'h4000_0000 - octant_turns(b, a);
    else phi = octant_turns(a, b);
    return quarter * 32'h4000_0000 + phi;
  endfunction

  function automatic out_item_t classify_pixel(in_item_t p);
    longint dx, dy, d2, r, t, inner;
    longint unsigned pct, arc_end, ang;
    out_item_t res;
    dx = longint'(p.pixel_x) - longint'(ring_cx);
    dy = longint'(p.pixel_y) - longint'(ring_cy);
    d2 = dx * dx + dy * dy;
    r  = longint'(ring_r);
    // zero thickness falls back to the default of 4
    t  = (ring_t != 0) ? longint'(ring_t) : 4;
    // thickness past the radius turns the band into a full disc
    inner = (r > t) ? r - t : 0;
    res.pixel_on = 1'b0;
    res.region   = REGION_OUTSIDE;
    if (d2 < inner * inner || d2 > r * r) return res;
    // zero full scale reads as zero percent
    pct = (prog_full != 0) ? (longint'(prog_val) * 100) / longint'(prog_full) : 0;
    if (pct > 100) pct = 100;
    arc_end = (pct << ANGLE_W) / 100;
    ang = longint'(sweep_turns(dx, dy) >> (32 - ANGLE_W));
    if (ang <= arc_end) begin
      res.pixel_on = 1'b1;
      res.region   = REGION_FILLED;
    end else begin
      res.pixel_on = (2'(p.pixel_x[1:0] + p.pixel_y[1:0]) == 2'd0);
      res.region   = REGION_DITHER;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic in_item_t pix(int x, int y);
    in_item_t p;
    p.pixel_x = COORD_W'(x);
    p.pixel_y = COORD_W'(y);
    return p;
  endfunction

  // A pixel near the band: radius drawn from just inside the inner edge to
  // just past the outer edge, at a random angle. Off-screen picks fall back
  // to a random coordinate.
  function automatic in_item_t ring_pixel();
    int r, t, inner, lo, rad, dx, dy, x, y;
    r     = int'(ring_r);
    t     = (ring_t != 0) ? int'(ring_t) : 4;
    inner = (r > t) ? r - t : 0;
    lo    = (inner > 2) ? inner - 2 : 0;
    rad   = int'($urandom_range(r + 2, lo));
    dx    = int'($urandom_range(2 * rad, 0)) - rad;
    dy    = int'($sqrt(real'(rad * rad - dx * dx)));
    if ($urandom_range(1, 0) == 1) dy = -dy;
    x = int'(ring_cx) + dx;
    y = int'(ring_cy) + dy;
    if (x < 0 || x > COORD_MAX) x = int'($urandom_range(COORD_MAX, 0));
    if (y < 0 || y > COORD_MAX) y = int'($urandom_range(COORD_MAX, 0));
    return pix(x, y);
  endfunction

  // APB write: setup then access; the register takes it at the access edge.
  // Waits out the end-angle divide left running by an earlier write.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    while (busy) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CENTER_X:   ring_cx   = val[COORD_W-1:0];
      REG_CENTER_Y:   ring_cy   = val[COORD_W-1:0];
      REG_OUTER_RAD:  ring_r    = val[RADIUS_W-1:0];
      REG_THICKNESS:  ring_t    = val[RADIUS_W-1:0];
      REG_PROG_VALUE: prog_val  = val[PROG_W-1:0];
      REG_PROG_MAX:   prog_full = val[PROG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_ring(input int cx, input int cy, input int r, input int t,
                          input int v, input int m);
    reg_write(REG_CENTER_X, cx);
    reg_write(REG_CENTER_Y, cy);
    reg_write(REG_OUTER_RAD, r);
    reg_write(REG_THICKNESS, t);
    reg_write(REG_PROG_VALUE, v);
    reg_write(REG_PROG_MAX, m);
    settings++;
    @(posedge clk);
  endtask

  // Random gauge; junk above each field's width must be dropped.
  task automatic pick_ring();
    int r, t, m, v;
    r = ($urandom_range(3, 0) == 0) ? int'($urandom_range(511, 0))
                                    : int'($urandom_range(200, 8));
    case ($urandom_range(7, 0))
      0:       t = 0;
      1:       t = (r < 511) ? int'($urandom_range(511, r + 1)) : 511;
      2:       t = int'($urandom_range(511, 1));
      default: t = int'($urandom_range(40, 1));
    endcase
    case ($urandom_range(9, 0))
      0:       begin m = 0; v = int'($urandom_range(65535, 0)); end
      1:       begin m = int'($urandom_range(1000, 1)); v = int'($urandom_range(65535, m)); end
      2:       begin m = 65535; v = int'($urandom_range(65535, 0)); end
      default: begin m = int'($urandom_range(65535, 1)); v = int'($urandom_range(m, 0)); end
    endcase
    reg_write(REG_CENTER_X, ($urandom & ~32'h3FF) | $urandom_range(COORD_MAX, 0));
    reg_write(REG_CENTER_Y, ($urandom & ~32'h3FF) | $urandom_range(COORD_MAX, 0));
    reg_write(REG_OUTER_RAD, ($urandom & ~32'h1FF) | r);
    reg_write(REG_THICKNESS, ($urandom & ~32'h1FF) | t);
    reg_write(REG_PROG_VALUE, ($urandom & ~32'hFFFF) | v);
    reg_write(REG_PROG_MAX, ($urandom & ~32'hFFFF) | m);
    settings++;
    @(posedge clk);
  endtask

  // Registers may only change with the pipe empty.
  task automatic settle();
    do @(posedge clk);
    while (scan_queue.size() != 0 || start || predicted_class.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the next pixel at the falling edge once the last one
  // was taken, with random bursts of idle cycles between pixels.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (scan_queue.size() != 0 && $urandom_range(99, 0) < gap_pct) begin
        gap_left = int'($urandom_range(11, 0));
        start <= 1'b0;
      end else if (scan_queue.size() != 0) begin
        in_item <= scan_queue.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result strobe against the oldest prediction, then
  // records a pixel taken at this edge. Checking first keeps a stray strobe
  // from consuming the prediction of the pixel taken on the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, predicted_class.size());
      $display("Mismatches found");
      $finish;
    end else if (!rst_n) begin
      item_taken = 1'b0;
    end else begin
      if (out_valid) begin
        if (predicted_class.size() == 0) begin
          $error("unexpected result: pixel_on=%0d region=%0d",
                 out_item.pixel_on, out_item.region);
          mismatches++;
        end else begin
          want = predicted_class.pop_front();
          if (out_item.pixel_on !== want.pixel_on) begin
            $error("pixel_on: expected %0d, actual %0d", want.pixel_on, out_item.pixel_on);
            mismatches++;
          end
          if (out_item.region !== want.region) begin
            $error("region: expected %0d, actual %0d", want.region, out_item.region);
            mismatches++;
          end
          region_hits[want.region]++;
        end
      end
      item_taken = start && !busy;
      if (item_taken) begin
        predicted_class.push_back(classify_pixel(in_item));
        pixels_in++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int n, k, random_pix;
    random_pix = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset gauge: radius 0 with the default thickness leaves only the
    // center pixel in the band, and zero full scale gives zero percent.
    scan_queue.push_back(pix(0, 0));
    scan_queue.push_back(pix(COORD_MAX, COORD_MAX));
    scan_queue.push_back(pix(COORD_MAX, 0));
    scan_queue.push_back(pix(0, COORD_MAX));
    settle();

    // Half-filled ring, zero thickness standing in for 4: compass points,
    // band edges, both diagonals, dither on and off, the hollow center.
    set_ring(512, 512, 100, 0, 50, 100);
    scan_queue.push_back(pix(512, 412));
    scan_queue.push_back(pix(612, 512));
    scan_queue.push_back(pix(512, 612));   // exactly at the arc end
    scan_queue.push_back(pix(412, 512));
    scan_queue.push_back(pix(411, 512));
    scan_queue.push_back(pix(512, 416));   // inner edge
    scan_queue.push_back(pix(512, 417));
    scan_queue.push_back(pix(582, 582));
    scan_queue.push_back(pix(442, 442));
    scan_queue.push_back(pix(443, 442));
    scan_queue.push_back(pix(512, 512));
    settle();

    // Thickness past the radius: full disc, center pixel included; full arc.
    set_ring(20, 1000, 10, 511, 65535, 65535);
    scan_queue.push_back(pix(20, 1000));
    scan_queue.push_back(pix(10, 1000));
    scan_queue.push_back(pix(20, 1010));
    settle();

    // Largest radius from the corner, value far past full scale, and
    // writes to undecoded slots that must leave the gauge alone.
    set_ring(0, 0, 511, 200, 65535, 1);
    reg_write(REG_SPARE_A, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_B, 32'h0000_0001);
    @(posedge clk);
    scan_queue.push_back(pix(511, 0));
    scan_queue.push_back(pix(0, 511));
    scan_queue.push_back(pix(361, 361));
    scan_queue.push_back(pix(COORD_MAX, COORD_MAX));
    settle();

    // Opposite corner, one-pixel band, zero percent.
    set_ring(COORD_MAX, COORD_MAX, 511, 1, 0, 65535);
    scan_queue.push_back(pix(COORD_MAX, 512));
    scan_queue.push_back(pix(512, COORD_MAX));
    scan_queue.push_back(pix(COORD_MAX, 513));
    settle();

    // Random gauges; most pixels aimed at the band, the rest anywhere.
    // Idle bursts vary per setting and stop near the end.
    while (random_pix < RANDOM_PIX) begin
      pick_ring();
      if (random_pix > RANDOM_PIX - 150) gap_pct = 0;
      else gap_pct = ($urandom_range(3, 0) == 0) ? 0 : int'($urandom_range(40, 5));
      n = int'($urandom_range(70, 30));
      for (k = 0; k < n; k++) begin
        case ($urandom_range(9, 0))
          0, 1: scan_queue.push_back(pix($urandom_range(COORD_MAX, 0),
                                         $urandom_range(COORD_MAX, 0)));
          2: begin
            if ($urandom_range(1, 0) == 1) scan_queue.push_back(pix(ring_cx, ring_cy));
            else scan_queue.push_back(pix($urandom_range(1, 0) * COORD_MAX,
                                          $urandom_range(1, 0) * COORD_MAX));
          end
          default: scan_queue.push_back(ring_pixel());
        endcase
      end
      random_pix += n;
      settle();
    end

    repeat (DRAIN_CYC) @(posedge clk);
    if (predicted_class.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_class.size());
      mismatches++;
    end

    $display("Classified %0d pixels under %0d gauge settings: %0d outside, %0d filled, %0d dithered",
             pixels_in, settings, region_hits[REGION_OUTSIDE],
             region_hits[REGION_FILLED], region_hits[REGION_DITHER]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
